[rtl/intt_pkg.sv]
// ----------------------------------------------------------------------------
// intt_pkg
// shared constants, twiddle table and modular helpers for the inverse ntt
// ----------------------------------------------------------------------------
package intt_pkg;

	localparam int POLY_SIZE_DEF = 256;
	localparam int LANES_DEF     = 4;
	localparam int QUEUE_DEPTH   = 2;
	localparam int CW            = 14;
	localparam logic [CW-1:0] Q_MOD = 14'd12289;
	localparam logic [15:0] Q_NEG_INV = 16'd12287;
	localparam logic [CW-1:0] SCALE = 14'd256;

	typedef logic [CW-1:0] coeff_t;

	localparam logic [CW-1:0] TWIDDLE_ROM [256] = '{
		14'd4091, 14'd4401, 14'd1081, 14'd1229, 14'd2530, 14'd6014, 14'd7947, 14'd5329,
		14'd2579, 14'd4751, 14'd6464, 14'd11703, 14'd7023, 14'd2812, 14'd5890, 14'd10698,
		14'd3109, 14'd2125, 14'd1960, 14'd10925, 14'd10601, 14'd10404, 14'd4189, 14'd1875,
		14'd5847, 14'd8546, 14'd4615, 14'd5190, 14'd11324, 14'd10578, 14'd5882, 14'd11155,
		14'd8417, 14'd12275, 14'd10599, 14'd7446, 14'd5719, 14'd3569, 14'd5981, 14'd10108,
		14'd4426, 14'd8306, 14'd10755, 14'd4679, 14'd11052, 14'd1538, 14'd11857, 14'd100,
		14'd8247, 14'd6625, 14'd9725, 14'd5145, 14'd3412, 14'd7858, 14'd5831, 14'd9460,
		14'd5217, 14'd10740, 14'd7882, 14'd7506, 14'd12172, 14'd11292, 14'd6049, 14'd79,
		14'd13, 14'd6938, 14'd8886, 14'd5453, 14'd4586, 14'd11455, 14'd2903, 14'd4676,
		14'd9843, 14'd7621, 14'd8822, 14'd9109, 14'd2083, 14'd8507, 14'd8685, 14'd3110,
		14'd7015, 14'd3269, 14'd1367, 14'd6397, 14'd10259, 14'd8435, 14'd10527, 14'd11559,
		14'd11094, 14'd2211, 14'd1808, 14'd7319, 14'd48, 14'd9547, 14'd2560, 14'd1228,
		14'd9438, 14'd10787, 14'd11800, 14'd1820, 14'd11406, 14'd8966, 14'd6159, 14'd3012,
		14'd6109, 14'd2796, 14'd2203, 14'd1652, 14'd711, 14'd7004, 14'd1053, 14'd8973,
		14'd5244, 14'd1517, 14'd9322, 14'd11269, 14'd900, 14'd3888, 14'd11133, 14'd10736,
		14'd4949, 14'd7616, 14'd9974, 14'd4746, 14'd10270, 14'd126, 14'd2921, 14'd6720,
		14'd6635, 14'd6543, 14'd1582, 14'd4868, 14'd42, 14'd673, 14'd2240, 14'd7219,
		14'd1296, 14'd11989, 14'd7675, 14'd8578, 14'd11949, 14'd989, 14'd10541, 14'd7687,
		14'd7085, 14'd8487, 14'd1004, 14'd10236, 14'd4703, 14'd163, 14'd9143, 14'd4597,
		14'd6431, 14'd12052, 14'd2991, 14'd11938, 14'd4647, 14'd3362, 14'd2060, 14'd11357,
		14'd12011, 14'd6664, 14'd5655, 14'd7225, 14'd5914, 14'd9327, 14'd4092, 14'd5880,
		14'd6932, 14'd3402, 14'd5133, 14'd9394, 14'd11229, 14'd5252, 14'd9008, 14'd1556,
		14'd6908, 14'd4773, 14'd3853, 14'd8780, 14'd10325, 14'd7737, 14'd1758, 14'd7103,
		14'd11375, 14'd12273, 14'd8602, 14'd3243, 14'd6536, 14'd7590, 14'd8591, 14'd11552,
		14'd6101, 14'd3253, 14'd9969, 14'd9640, 14'd4506, 14'd3736, 14'd6829, 14'd10822,
		14'd9130, 14'd9948, 14'd3566, 14'd2133, 14'd3901, 14'd6038, 14'd7333, 14'd6609,
		14'd3468, 14'd4659, 14'd625, 14'd2700, 14'd7738, 14'd3443, 14'd3060, 14'd3388,
		14'd3526, 14'd4418, 14'd11911, 14'd6232, 14'd1730, 14'd2558, 14'd10340, 14'd5344,
		14'd5286, 14'd2190, 14'd11562, 14'd6199, 14'd2482, 14'd8756, 14'd5387, 14'd4101,
		14'd4609, 14'd8605, 14'd8226, 14'd144, 14'd5656, 14'd8704, 14'd2621, 14'd5424,
		14'd10812, 14'd2959, 14'd11346, 14'd6249, 14'd1715, 14'd4951, 14'd9540, 14'd1888,
		14'd3764, 14'd39, 14'd8219, 14'd2080, 14'd2502, 14'd1469, 14'd10550, 14'd8709
	};

	function automatic coeff_t reduce_once(input logic [CW-1:0] a);
		reduce_once = (a >= Q_MOD) ? a - Q_MOD : a;
	endfunction

	function automatic coeff_t add_q(input coeff_t a, input coeff_t b);
		logic [CW:0] s;
		s = {1'b0, a} + {1'b0, b};
		add_q = (s >= {1'b0, Q_MOD}) ? CW'(s - {1'b0, Q_MOD}) : s[CW-1:0];
	endfunction

	function automatic coeff_t sub_q(input coeff_t a, input coeff_t b);
		sub_q = (a >= b) ? a - b : CW'({1'b0, a} + {1'b0, Q_MOD} - {1'b0, b});
	endfunction

endpackage

[rtl/intt_if.sv]
// ----------------------------------------------------------------------------
// intt_if
// valid/ready channel carrying a group of coefficients
// ----------------------------------------------------------------------------
interface intt_if #(
	parameter int LANES = intt_pkg::LANES_DEF
);
	logic valid;
	logic ready;
	intt_pkg::coeff_t coeff [LANES];
	logic last;

	modport source (output valid, output coeff, output last, input ready);
	modport sink (input valid, input coeff, input last, output ready);
endinterface

[rtl/intt_mont.sv]
// ----------------------------------------------------------------------------
// intt_mont
// three-stage pipelined montgomery multiplier, r = 2^16
// ----------------------------------------------------------------------------
module intt_mont (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  intt_pkg::coeff_t a,
	input  intt_pkg::coeff_t b,
	input  logic [7:0]       in_tag,
	output logic             out_valid,
	output intt_pkg::coeff_t r,
	output logic [7:0]       out_tag
);
	logic [27:0] prod_s1;
	logic [15:0] m_s2;
	logic [27:0] prod_s2;
	logic [29:0] sum_s3;
	logic [2:0]  vld_q;
	logic [7:0]  tag_s1, tag_s2, tag_s3;
	logic [31:0] m_full;
	logic [13:0] sh;

	assign m_full = 32'(prod_s1[15:0]) * 32'(intt_pkg::Q_NEG_INV);

	always_ff @(posedge clk) begin
		prod_s1 <= 28'(a) * 28'(b);
		tag_s1  <= in_tag;
		m_s2    <= m_full[15:0];
		prod_s2 <= prod_s1;
		tag_s2  <= tag_s1;
		sum_s3  <= 30'(prod_s2) + 30'(m_s2) * 30'(intt_pkg::Q_MOD);
		tag_s3  <= tag_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[1:0], in_valid};
	end

	assign sh = sum_s3[29:16];
	assign r = intt_pkg::reduce_once(sh);
	assign out_valid = vld_q[2];
	assign out_tag = tag_s3;
endmodule

[rtl/intt_front.sv]
// ----------------------------------------------------------------------------
// intt_front
// accepts input items, reduces lanes and queues them for the core
// ----------------------------------------------------------------------------
module intt_front #(
	parameter int LANES = intt_pkg::LANES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	intt_if.sink   in_ch,
	intt_if.source q_ch
);
	localparam int DEPTH = intt_pkg::QUEUE_DEPTH;
	localparam int PW = $clog2(DEPTH);
	intt_pkg::coeff_t buf_q [DEPTH][LANES];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;
	logic push, pop;

	assign in_ch.ready = (cnt_q != (PW+1)'(DEPTH));
	assign push = in_ch.valid && in_ch.ready;
	assign pop  = q_ch.valid && q_ch.ready;
	assign q_ch.valid = (cnt_q != '0);
	assign q_ch.last = 1'b0;

	always_comb begin
		for (int l = 0; l < LANES; l++) q_ch.coeff[l] = buf_q[rp_q][l];
	end

	always_ff @(posedge clk) begin
		if (push)
			for (int l = 0; l < LANES; l++)
				buf_q[wp_q][l] <= intt_pkg::reduce_once(in_ch.coeff[l]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= PW'((32'(wp_q) + 1) % DEPTH);
			if (pop) rp_q <= PW'((32'(rp_q) + 1) % DEPTH);
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (PW+1)'(DEPTH))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count lost a push");
	assert property (@(posedge clk) disable iff (!arst_n) (cnt_q == '0) |-> !q_ch.valid)
		else $error("empty queue shows valid");
endmodule

[rtl/intt_core.sv]
// ----------------------------------------------------------------------------
// intt_core
// coefficient memory, butterfly sequencer and output stream
// ----------------------------------------------------------------------------
module intt_core #(
	parameter int POLY_SIZE = intt_pkg::POLY_SIZE_DEF,
	parameter int LANES = intt_pkg::LANES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	intt_if.sink   q_ch,
	intt_if.source out_ch
);
	localparam int AW = $clog2(POLY_SIZE);
	localparam int ITEMS = POLY_SIZE / LANES;
	localparam int IW = $clog2(ITEMS);
	localparam int LW = $clog2(LANES);
	localparam logic [2:0] ST_LOAD = 3'd0, ST_BF_RD = 3'd1, ST_BF_WAIT = 3'd2,
		ST_SC_RD = 3'd3, ST_SC_WAIT = 3'd4, ST_OUT = 3'd5;

	intt_pkg::coeff_t mem_q [POLY_SIZE];
	logic [2:0] st_q;
	logic [IW-1:0] ld_q;
	logic [3:0] stg_q;
	logic [AW-1:0] bf_q;
	logic [AW:0] sc_q;
	logic [IW-1:0] ob_q;
	logic [LW:0] ol_q;
	logic [AW-1:0] ia, ib;
	intt_pkg::coeff_t u_q, v_q, tw_q, x0_q, m_r;
	logic m_vld, m_in;
	logic [7:0] m_tag;
	intt_pkg::coeff_t m_a, m_b;
	logic [1:0] rd_q;
	logic [AW-1:0] rd_ia_q, rd_ib_q;
	intt_pkg::coeff_t obuf_q [LANES];
	logic ovalid_q, olast_q;
	logic [AW-1:0] half_mask;
	logic [AW-1:0] grp, low;

	// butterfly index from stage and counter
	always_comb begin
		half_mask = AW'((1 << stg_q) - 1);
		low = bf_q[AW-2:0] & half_mask[AW-2:0];
		grp = AW'(bf_q[AW-2:0] >> stg_q);
		ia = AW'((32'(grp) << (stg_q + 1)) | 32'(low));
		ib = AW'(32'(ia) | (1 << stg_q));
	end

	assign q_ch.ready = (st_q == ST_LOAD);
	assign out_ch.valid = ovalid_q;
	assign out_ch.last = olast_q;
	always_comb for (int l = 0; l < LANES; l++) out_ch.coeff[l] = obuf_q[l];

	assign m_in = (st_q == ST_BF_WAIT && rd_q == 2'd2) ||
		(st_q == ST_SC_WAIT && rd_q == 2'd1);
	assign m_a = (st_q == ST_BF_WAIT) ? intt_pkg::sub_q(u_q, v_q) : u_q;
	assign m_b = (st_q == ST_BF_WAIT) ? tw_q : intt_pkg::SCALE;

	intt_mont u_mont (
		.clk(clk), .arst_n(arst_n), .in_valid(m_in), .a(m_a), .b(m_b),
		.in_tag(8'(rd_ib_q)), .out_valid(m_vld), .r(m_r), .out_tag(m_tag)
	);

	always_ff @(posedge clk) begin
		if (q_ch.valid && q_ch.ready)
			for (int l = 0; l < LANES; l++)
				mem_q[AW'(32'(ld_q) * LANES + l)] <= q_ch.coeff[l];
		if (st_q == ST_BF_RD) begin
			u_q <= mem_q[ia];
			v_q <= mem_q[ib];
			tw_q <= intt_pkg::TWIDDLE_ROM[8'((ITEMS*LANES >> (stg_q + 1)) +
				(32'(bf_q[AW-2:0]) >> stg_q))];
			rd_ia_q <= ia;
			rd_ib_q <= ib;
		end
		if (st_q == ST_SC_RD) begin
			u_q <= mem_q[sc_q[AW-1:0]];
			rd_ib_q <= sc_q[AW-1:0];
		end
		if (st_q == ST_BF_WAIT && rd_q == 2'd2) x0_q <= intt_pkg::add_q(u_q, v_q);
		if (st_q == ST_BF_WAIT && rd_q == 2'd1) mem_q[rd_ia_q] <= x0_q;
		if (m_vld) mem_q[AW'(m_tag)] <= m_r;
		if (st_q == ST_OUT && ol_q != (LW+1)'(LANES))
			obuf_q[ol_q[LW-1:0]] <= mem_q[AW'(32'(ob_q) * LANES + 32'(ol_q))];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
			ld_q <= '0;
			stg_q <= '0;
			bf_q <= '0;
			sc_q <= '0;
			ob_q <= '0;
			ol_q <= '0;
			rd_q <= '0;
			ovalid_q <= 1'b0;
			olast_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_LOAD: if (q_ch.valid) begin
					ld_q <= ld_q + 1'b1;
					if (ld_q == IW'(ITEMS-1)) begin
						st_q <= ST_BF_RD;
						stg_q <= '0;
						bf_q <= '0;
					end
				end
				ST_BF_RD: begin
					st_q <= ST_BF_WAIT;
					rd_q <= 2'd2;
				end
				ST_BF_WAIT: begin
					// wait for product to land so next read sees it
					if (rd_q != 2'd0) rd_q <= rd_q - 1'b1;
					else if (m_vld) begin
						if (bf_q == AW'(POLY_SIZE/2-1)) begin
							bf_q <= '0;
							if (stg_q == 4'(AW-1)) begin
								st_q <= ST_SC_RD;
								sc_q <= '0;
							end else begin
								stg_q <= stg_q + 1'b1;
								st_q <= ST_BF_RD;
							end
						end else begin
							bf_q <= bf_q + 1'b1;
							st_q <= ST_BF_RD;
						end
					end
				end
				ST_SC_RD: begin
					st_q <= ST_SC_WAIT;
					rd_q <= 2'd1;
				end
				ST_SC_WAIT: begin
					if (rd_q != 2'd0) rd_q <= rd_q - 1'b1;
					else if (m_vld) begin
						if (sc_q == (AW+1)'(POLY_SIZE-1)) begin
							st_q <= ST_OUT;
							ob_q <= '0;
							ol_q <= '0;
						end else begin
							sc_q <= sc_q + 1'b1;
							st_q <= ST_SC_RD;
						end
					end
				end
				ST_OUT: begin
					if (ovalid_q) begin
						if (out_ch.ready) begin
							ovalid_q <= 1'b0;
							if (olast_q) begin
								olast_q <= 1'b0;
								st_q <= ST_LOAD;
							end else begin
								ob_q <= ob_q + 1'b1;
								ol_q <= '0;
							end
						end
					end else if (ol_q != (LW+1)'(LANES)) ol_q <= ol_q + 1'b1;
					else begin
						ovalid_q <= 1'b1;
						olast_q <= (ob_q == IW'(ITEMS-1));
					end
				end
				default: st_q <= ST_LOAD;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> st_q == ST_OUT)
		else $error("result shown outside output phase");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(ob_q))
		else $error("stalled result moved");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_vld |-> (st_q == ST_BF_WAIT || st_q == ST_SC_WAIT))
		else $error("stray product");
endmodule

[rtl/inverse_ntt_256_mod_12289.sv]
// ----------------------------------------------------------------------------
// inverse_ntt_256_mod_12289
// inverse ntt over q = 12289, 256 points, montgomery twiddles
// ----------------------------------------------------------------------------
// usage: in_ch carries four coefficients per transfer, index 4k+lane. values
// at or above q are reduced once. after 64 input transfers the core runs 8
// stages of 128 butterflies and a scaling pass, then sends 64 output
// transfers on out_ch in natural order, last set on the final one.
// each butterfly is a memory read followed by a pass through the three-stage
// montgomery multiplier and write-back, and the next read waits for that
// write (read-after-write on the store); each scaling step works the same
// way, and each output transfer gathers its lanes from the store one at a
// time before it is shown.
// a two-entry queue decouples the input side, which keeps taking transfers
// while the core loads. inputs are held off while the transform runs.
// reset clears all control state; the store needs no clearing since every
// entry is written before it is read. a stalled receiver holds the output
// transfer and the core waits.
// ----------------------------------------------------------------------------
module inverse_ntt_256_mod_12289 #(
	parameter int POLY_SIZE = intt_pkg::POLY_SIZE_DEF,
	parameter int LANES = intt_pkg::LANES_DEF
) (
	input logic clk,
	input logic arst_n,
	intt_if.sink   in_ch,
	intt_if.source out_ch
);
	intt_if #(.LANES(LANES)) q_ch ();

	intt_front #(.LANES(LANES)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .q_ch(q_ch)
	);

	intt_core #(.POLY_SIZE(POLY_SIZE), .LANES(LANES)) u_core (
		.clk(clk), .arst_n(arst_n), .q_ch(q_ch), .out_ch(out_ch)
	);
endmodule
